/* design/grid_cell_geometry_assert.svh */
// ---------------------------------------------------------------------------
// grid_cell_geometry assertion macros
// Concurrent assertion shorthands, clocked on clk, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_CELL_GEOMETRY_ASSERT_SVH
`define GRID_CELL_GEOMETRY_ASSERT_SVH

// same-cycle implication
`define GCG_ASSERT_IMP(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("gcg assertion failed");

// next-cycle implication
`define GCG_ASSERT_NXT(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("gcg assertion failed");

`endif

/* design/gcg_pkg.sv */
// ---------------------------------------------------------------------------
// gcg_pkg
// Types, codes and constants shared by the grid cell geometry block.
// ---------------------------------------------------------------------------
package gcg_pkg;

	localparam int COORD_BITS     = 12;
	localparam int MAX_CELLS      = 64;
	localparam int LEN_BITS       = 12;
	localparam int COUNT_BITS     = 7;
	localparam int BORDER_BITS    = 8;
	localparam int INDEX_BITS     = 6;
	localparam int EXTRA_BITS     = 6;
	localparam int CFG_DATA_BITS  = 12;
	localparam int CFG_INDEX_BITS = 3;
	localparam int QUEUE_DEPTH    = 2;	// power of two

	localparam logic [LEN_BITS-1:0]    RST_AREA     = LEN_BITS'(100);
	localparam logic [COUNT_BITS-1:0]  RST_COUNT    = COUNT_BITS'(3);
	localparam logic [BORDER_BITS-1:0] RST_BORDER   = BORDER_BITS'(10);
	localparam logic [COORD_BITS-1:0]  RST_CELL_LEN = COORD_BITS'(26);
	localparam logic [EXTRA_BITS-1:0]  RST_EXTRA    = EXTRA_BITS'(2);

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_AREA_WIDTH   = 3'd0,
		REG_AREA_HEIGHT  = 3'd1,
		REG_ROW_COUNT    = 3'd2,
		REG_COLUMN_COUNT = 3'd3,
		REG_BORDER_WIDTH = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_CELL    = 2'd0,
		KIND_VBORDER = 2'd1,
		KIND_HBORDER = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_SUCCESS        = 2'd0,
		ST_INVALID_INDEX  = 2'd1,
		ST_INVALID_LAYOUT = 2'd2
	} status_t;

	// what one axis of a query produces
	typedef enum logic [1:0] {
		AX_CELL   = 2'd0,	// cell start, cell size
		AX_BORDER = 2'd1,	// end of cell + 1, border width
		AX_FULL   = 2'd2	// zero, whole area length
	} axis_mode_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [INDEX_BITS-1:0] row_index;
		logic [INDEX_BITS-1:0] column_index;
	} query_t;

	typedef struct packed {
		logic [1:0] status;
		coord_t     start_x;
		coord_t     start_y;
		coord_t     end_x;
		coord_t     end_y;
		coord_t     box_width;
		coord_t     box_height;
	} result_t;

	typedef struct packed {
		axis_mode_t            mode;
		logic [INDEX_BITS-1:0] idx;
	} axis_op_t;

	typedef struct packed {
		status_t  status;
		axis_op_t x;
		axis_op_t y;
	} entry_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]   len;
		logic [COUNT_BITS-1:0] count;
		coord_t                cell_len;
		logic [EXTRA_BITS-1:0] extra;
	} axis_geom_t;

	typedef struct packed {
		axis_geom_t             h;
		axis_geom_t             v;
		logic [BORDER_BITS-1:0] border;
		logic                   layout_ok;
	} geom_t;

endpackage

/* design/gcg_cfg.sv */
// ---------------------------------------------------------------------------
// gcg_cfg
// Register file plus per-axis layout check and restoring divider that
// derives cell length and remainder after every register write.
// ---------------------------------------------------------------------------
module gcg_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gcg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [gcg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output gcg_pkg::geom_t                       geom,
	output logic                                 busy
);
	import gcg_pkg::*;

	localparam int DIV_STEPS = LEN_BITS;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);
	localparam int REM_BITS  = COUNT_BITS;

	typedef enum logic [2:0] {
		CS_IDLE = 3'b001,
		CS_LOAD = 3'b010,
		CS_DIV  = 3'b100
	} cs_t;

	cs_t state_q;

	logic [LEN_BITS-1:0]    area_w_q, area_h_q;
	logic [COUNT_BITS-1:0]  rows_q, cols_q;
	logic [BORDER_BITS-1:0] bw_q;
	coord_t                 cl_h_q, cl_v_q;
	logic [EXTRA_BITS-1:0]  ex_h_q, ex_v_q;
	logic                   layout_ok_q;
	logic                   ok_h_q, ok_v_q;
	logic [REM_BITS-1:0]    rem_h_q, rem_v_q;
	logic [LEN_BITS-1:0]    quo_h_q, quo_v_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   wr_hit;
	logic [REM_BITS+LEN_BITS-1:0] step_h, step_v;

	localparam int SPAN_BITS = BORDER_BITS + COUNT_BITS;

	function automatic logic [SPAN_BITS-1:0] border_span(
		logic [COUNT_BITS-1:0] n, logic [BORDER_BITS-1:0] b);
		return SPAN_BITS'(b) * SPAN_BITS'(n - COUNT_BITS'(1));
	endfunction

	function automatic logic axis_ok(logic [LEN_BITS-1:0] len, logic [COUNT_BITS-1:0] n,
		logic [BORDER_BITS-1:0] b);
		return (n != '0) && (32'(n) <= MAX_CELLS) &&
			(border_span(n, b) <= SPAN_BITS'(len));
	endfunction

	// one restoring step: {remainder, quotient shift register}
	function automatic logic [REM_BITS+LEN_BITS-1:0] div_step(
		logic [REM_BITS-1:0] rem, logic [LEN_BITS-1:0] quo, logic [COUNT_BITS-1:0] d);
		logic [REM_BITS:0] trial;
		logic [REM_BITS:0] diff;
		logic              bit_q;
		begin
			trial = {rem, quo[LEN_BITS-1]};
			diff  = trial - (REM_BITS+1)'(d);
			bit_q = (trial >= (REM_BITS+1)'(d));
			return {(bit_q ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0]),
				quo[LEN_BITS-2:0], bit_q};
		end
	endfunction

	always_comb begin
		case (cfg_reg_t'(cfg_index))
			REG_AREA_WIDTH, REG_AREA_HEIGHT, REG_ROW_COUNT,
			REG_COLUMN_COUNT, REG_BORDER_WIDTH: wr_hit = cfg_we;
			default: wr_hit = 1'b0;
		endcase
	end

	assign step_h = div_step(rem_h_q, quo_h_q, cols_q);
	assign step_v = div_step(rem_v_q, quo_v_q, rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_w_q <= RST_AREA;
			area_h_q <= RST_AREA;
			rows_q   <= RST_COUNT;
			cols_q   <= RST_COUNT;
			bw_q     <= RST_BORDER;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_AREA_WIDTH:   area_w_q <= cfg_data[LEN_BITS-1:0];
				REG_AREA_HEIGHT:  area_h_q <= cfg_data[LEN_BITS-1:0];
				REG_ROW_COUNT:    rows_q   <= cfg_data[COUNT_BITS-1:0];
				REG_COLUMN_COUNT: cols_q   <= cfg_data[COUNT_BITS-1:0];
				REG_BORDER_WIDTH: bw_q     <= cfg_data[BORDER_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			cnt_q       <= '0;
			ok_h_q      <= 1'b1;
			ok_v_q      <= 1'b1;
			cl_h_q      <= RST_CELL_LEN;
			cl_v_q      <= RST_CELL_LEN;
			ex_h_q      <= RST_EXTRA;
			ex_v_q      <= RST_EXTRA;
			layout_ok_q <= 1'b1;
		end else if (wr_hit) begin
			state_q <= CS_LOAD;	// a new write restarts the solve
		end else begin
			case (state_q)
				CS_LOAD: begin
					ok_h_q  <= axis_ok(area_w_q, cols_q, bw_q);
					ok_v_q  <= axis_ok(area_h_q, rows_q, bw_q);
					cnt_q   <= CNT_BITS'(DIV_STEPS - 1);
					state_q <= CS_DIV;
				end
				CS_DIV: begin
					cnt_q <= cnt_q - CNT_BITS'(1);
					if (cnt_q == '0) begin
						cl_h_q      <= ok_h_q ? step_h[LEN_BITS-1:0] : '0;
						ex_h_q      <= ok_h_q ? step_h[LEN_BITS +: EXTRA_BITS] : '0;
						cl_v_q      <= ok_v_q ? step_v[LEN_BITS-1:0] : '0;
						ex_v_q      <= ok_v_q ? step_v[LEN_BITS +: EXTRA_BITS] : '0;
						layout_ok_q <= ok_h_q && ok_v_q;
						state_q     <= CS_IDLE;
					end
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	// divider datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == CS_LOAD) begin
			rem_h_q <= '0;
			rem_v_q <= '0;
			quo_h_q <= area_w_q - LEN_BITS'(border_span(cols_q, bw_q));
			quo_v_q <= area_h_q - LEN_BITS'(border_span(rows_q, bw_q));
		end else begin
			{rem_h_q, quo_h_q} <= step_h;
			{rem_v_q, quo_v_q} <= step_v;
		end
	end

	assign busy = cfg_we || (state_q != CS_IDLE);

	always_comb begin
		geom.h.len      = area_w_q;
		geom.h.count    = cols_q;
		geom.h.cell_len = cl_h_q;
		geom.h.extra    = ex_h_q;
		geom.v.len      = area_h_q;
		geom.v.count    = rows_q;
		geom.v.cell_len = cl_v_q;
		geom.v.extra    = ex_v_q;
		geom.border     = bw_q;
		geom.layout_ok  = layout_ok_q;
	end

endmodule

/* design/gcg_front.sv */
// ---------------------------------------------------------------------------
// gcg_front
// Query intake: checks layout and indexes, sets status and per-axis mode.
// ---------------------------------------------------------------------------
module gcg_front (
	input  logic            query_valid,
	output logic            query_ready,
	input  gcg_pkg::query_t query,
	input  gcg_pkg::geom_t  geom,
	input  logic            busy,
	input  logic            q_full,
	output logic            push,
	output gcg_pkg::entry_t push_data
);
	import gcg_pkg::*;

	logic row_ok, col_ok, vb_ok, hb_ok;

	assign query_ready = !q_full && !busy;
	assign push        = query_valid && query_ready;

	assign row_ok = {1'b0, query.row_index} < geom.v.count;
	assign col_ok = {1'b0, query.column_index} < geom.h.count;
	assign vb_ok  = ({1'b0, query.column_index} + COUNT_BITS'(1)) < geom.h.count;
	assign hb_ok  = ({1'b0, query.row_index} + COUNT_BITS'(1)) < geom.v.count;

	always_comb begin
		push_data.status = ST_SUCCESS;
		push_data.x.mode = AX_FULL;
		push_data.x.idx  = query.column_index;
		push_data.y.mode = AX_FULL;
		push_data.y.idx  = query.row_index;
		if (!geom.layout_ok) begin
			push_data.status = ST_INVALID_LAYOUT;
		end else begin
			case (kind_t'(query.kind))
				KIND_CELL: begin
					if (row_ok && col_ok) begin
						push_data.x.mode = AX_CELL;
						push_data.y.mode = AX_CELL;
					end else begin
						push_data.status = ST_INVALID_INDEX;
					end
				end
				KIND_VBORDER: begin
					if (vb_ok) push_data.x.mode = AX_BORDER;
					else push_data.status = ST_INVALID_INDEX;
				end
				KIND_HBORDER: begin
					if (hb_ok) push_data.y.mode = AX_BORDER;
					else push_data.status = ST_INVALID_INDEX;
				end
				default: push_data.status = ST_INVALID_INDEX;
			endcase
		end
	end

endmodule

/* design/gcg_queue.sv */
// ---------------------------------------------------------------------------
// gcg_queue
// Small FIFO between intake and geometry pipeline.
// ---------------------------------------------------------------------------
module gcg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gcg_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output gcg_pkg::entry_t pop_data
);
	import gcg_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]   cnt_q;

	assign full     = (cnt_q == (PTR_BITS+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PTR_BITS+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PTR_BITS+1)'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* design/gcg_back.sv */
// ---------------------------------------------------------------------------
// gcg_back
// Geometry pipeline: index product, start/size selection, end and output.
// ---------------------------------------------------------------------------
module gcg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  gcg_pkg::entry_t q_data,
	output logic            pop,
	input  gcg_pkg::geom_t  geom,
	output logic            result_valid,
	input  logic            result_ready,
	output gcg_pkg::result_t result
);
	import gcg_pkg::*;

	localparam int PROD_BITS = INDEX_BITS + COORD_BITS;

	logic adv;

	// stage 1
	logic                  vld_s1;
	entry_t                ent_s1;
	coord_t                prod_x_s1, prod_y_s1;
	logic [EXTRA_BITS-1:0] few_x_s1, few_y_s1;
	logic                  bump_x_s1, bump_y_s1;

	// stage 2
	logic    vld_s2;
	status_t status_s2;
	coord_t  org_x_s2, org_y_s2, dim_x_s2, dim_y_s2;

	logic    res_vld_q;
	result_t res_q;

	// i * (cell_len + border), wrapped to the coordinate width
	function automatic coord_t axis_prod(logic [INDEX_BITS-1:0] idx, coord_t cl,
		logic [BORDER_BITS-1:0] b);
		logic [PROD_BITS-1:0] p;
		begin
			p = PROD_BITS'(idx) * PROD_BITS'(coord_t'(cl + COORD_BITS'(b)));
			return p[COORD_BITS-1:0];
		end
	endfunction

	function automatic logic [EXTRA_BITS-1:0] axis_few(logic [INDEX_BITS-1:0] idx,
		logic [EXTRA_BITS-1:0] ex);
		return (EXTRA_BITS'(idx) < ex) ? EXTRA_BITS'(idx) : ex;
	endfunction

	assign adv = !res_vld_q || result_ready;
	assign pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= !q_empty;
			vld_s2    <= vld_s1;
			res_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1    <= q_data;
			prod_x_s1 <= axis_prod(q_data.x.idx, geom.h.cell_len, geom.border);
			prod_y_s1 <= axis_prod(q_data.y.idx, geom.v.cell_len, geom.border);
			few_x_s1  <= axis_few(q_data.x.idx, geom.h.extra);
			few_y_s1  <= axis_few(q_data.y.idx, geom.v.extra);
			bump_x_s1 <= EXTRA_BITS'(q_data.x.idx) < geom.h.extra;
			bump_y_s1 <= EXTRA_BITS'(q_data.y.idx) < geom.v.extra;
		end
	end

	coord_t start_x, start_y, size_x, size_y;

	assign start_x = prod_x_s1 + COORD_BITS'(few_x_s1);
	assign start_y = prod_y_s1 + COORD_BITS'(few_y_s1);
	assign size_x  = geom.h.cell_len + COORD_BITS'(bump_x_s1);
	assign size_y  = geom.v.cell_len + COORD_BITS'(bump_y_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= ent_s1.status;
			case (ent_s1.x.mode)
				AX_CELL: begin
					org_x_s2 <= start_x;
					dim_x_s2 <= size_x;
				end
				AX_BORDER: begin
					org_x_s2 <= start_x + size_x;
					dim_x_s2 <= COORD_BITS'(geom.border);
				end
				default: begin
					org_x_s2 <= '0;
					dim_x_s2 <= COORD_BITS'(geom.h.len);
				end
			endcase
			case (ent_s1.y.mode)
				AX_CELL: begin
					org_y_s2 <= start_y;
					dim_y_s2 <= size_y;
				end
				AX_BORDER: begin
					org_y_s2 <= start_y + size_y;
					dim_y_s2 <= COORD_BITS'(geom.border);
				end
				default: begin
					org_y_s2 <= '0;
					dim_y_s2 <= COORD_BITS'(geom.v.len);
				end
			endcase
		end
	end

	// error results carry all-zero geometry
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.status <= status_s2;
			if (status_s2 == ST_SUCCESS) begin
				res_q.start_x    <= org_x_s2;
				res_q.start_y    <= org_y_s2;
				res_q.end_x      <= org_x_s2 + dim_x_s2 - COORD_BITS'(1);
				res_q.end_y      <= org_y_s2 + dim_y_s2 - COORD_BITS'(1);
				res_q.box_width  <= dim_x_s2;
				res_q.box_height <= dim_y_s2;
			end else begin
				res_q.start_x    <= '0;
				res_q.start_y    <= '0;
				res_q.end_x      <= '0;
				res_q.end_y      <= '0;
				res_q.box_width  <= '0;
				res_q.box_height <= '0;
			end
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

/* design/grid_cell_geometry.sv */
// Path: queue, product stage, select stage, then end/output stage (output register).
// Throughput: one query per cycle when neither result back-pressure nor a register
//   write stalls intake; the product stage holds one 6x12 multiply.
// A register write holds query_ready low through the write, the load state and a
//   12-step restoring divide that yields cell length and remainder per axis.
// Reset (arst_n low, asynchronous) restores the register defaults and their
//   derived cell lengths, so queries are taken right after reset.
// ---------------------------------------------------------------------------
// grid_cell_geometry
// Cell and border rectangles of a pixel area split into a grid.
// ---------------------------------------------------------------------------
module grid_cell_geometry (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [gcg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [gcg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// query channel
	input  logic                                 query_valid,
	output logic                                 query_ready,
	input  gcg_pkg::query_t                      query,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output gcg_pkg::result_t                     result
);
	import gcg_pkg::*;

	// Live geometry: area lengths, counts, border, derived cell length/remainder per axis.
	// The user must change it only while no query is in flight; the block does not enforce it.
	geom_t  geom;
	logic   busy;

	// front -> queue -> back
	logic   push, pop, q_full, q_empty;
	entry_t push_data, pop_data;

	// Registers and the cell length solver. busy covers the write cycle
	// itself and the whole divide, so no query is accepted while geometry is re-solved.
	gcg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (busy)
	);

	// Front: classifies each transfer into status plus per-axis work
	// (cell, border or full span) and pushes it into the queue.
	gcg_front u_front (
		.query_valid (query_valid),
		.query_ready (query_ready),
		.query       (query),
		.geom        (geom),
		.busy        (busy),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	// Two-entry queue decouples intake from output backpressure.
	gcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	// Back: start(i) = i*(cl+b) + min(i,ex), size = cl + (i<ex),
	// end = start + size - 1, all wrapped to the coordinate width.
	gcg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.geom         (geom),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* design/gcg_checker.sv */
// ---------------------------------------------------------------------------
// gcg_checker
// Port-level checks on the grid cell geometry block, bound to its top.
// ---------------------------------------------------------------------------
`include "grid_cell_geometry_assert.svh"

module gcg_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_we,
	input logic [gcg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic                               query_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input gcg_pkg::result_t                   result
);
	import gcg_pkg::*;

	// a stalled result holds
	`GCG_ASSERT_NXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(result))

	// a register write stalls intake while the geometry is re-solved
	`GCG_ASSERT_NXT(a_cfg_stall, cfg_we && (cfg_index <= REG_BORDER_WIDTH), !query_ready)

	// error results carry no geometry
	`GCG_ASSERT_IMP(a_err_zero, result_valid && (result.status != ST_SUCCESS), (result.start_x == '0) && (result.start_y == '0) && (result.end_x == '0) && (result.end_y == '0) && (result.box_width == '0) && (result.box_height == '0))

	// rectangle ends follow start and size
	`GCG_ASSERT_IMP(a_end_rel, result_valid && (result.status == ST_SUCCESS), (result.end_x == COORD_BITS'(result.start_x + result.box_width - COORD_BITS'(1))) && (result.end_y == COORD_BITS'(result.start_y + result.box_height - COORD_BITS'(1))))

endmodule

bind grid_cell_geometry gcg_checker u_gcg_checker (.*);

/* test/grid_cell_geometry_tb.sv */
// ---------------------------------------------------------------------------
// grid_cell_geometry_tb
// Self-checking bench for the grid cell geometry block. Queries go in over a
// valid/ready channel with bursty timing, results are drained by a receiver
// with its own stall pattern, and every result is compared field by field
// against a rectangle computed in the bench from its own copy of the layout
// registers. The layout is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module grid_cell_geometry_tb;
	import gcg_pkg::*;

	// kind code that the block must reject as an index error
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// cycles with no transfer on either channel before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// cycles of margin after the last result, covers the pipeline depth
	localparam int DRAIN_PAUSE = 8;
	localparam int PHASES = 20;
	localparam int PHASE_QUERIES = 90;

	typedef struct {
		query_t q;
		bit     drain;	// hold this query back until every result is in
	} query_job_t;

	typedef enum int {
		RX_OPEN,	// always ready
		RX_COIN,	// ready half the time
		RX_SPARSE	// ready one cycle in four
	} rx_pace_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_AREA_WIDTH;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic             query_valid = 1'b0;
	logic             query_ready;
	query_t           query = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;

	// bench copy of the layout registers
	int unsigned grid_w      = RST_AREA;
	int unsigned grid_h      = RST_AREA;
	int unsigned grid_rows   = RST_COUNT;
	int unsigned grid_cols   = RST_COUNT;
	int unsigned grid_border = RST_BORDER;

	query_job_t queries_todo[$];	// waiting for the driver
	result_t    rects_due[$];		// predicted, waiting for the result channel

	int errors = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	// sender pacing
	int burst_left = 16;
	int gap_left = 0;
	query_job_t job;

	// receiver pacing
	rx_pace_t rx_pace = RX_OPEN;
	int pace_left = 0;
	int hold_left = 0;

	grid_cell_geometry dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Geometry of one axis
	// ------------------------------------------------------------------

	// An axis is usable when its count is 1..MAX_CELLS and the borders fit.
	function automatic bit axis_fits(input int unsigned len, input int unsigned n);
		if (n == 0 || n > MAX_CELLS)
			return 1'b0;
		return grid_border * (n - 1) <= len;
	endfunction

	// Even split of the free space; the first ex cells get one extra pixel.
	function automatic void axis_split(input int unsigned len, input int unsigned n,
			output int unsigned cl, output int unsigned ex);
		int unsigned free_len;
		free_len = len - grid_border * (n - 1);
		cl = free_len / n;
		ex = free_len % n;
	endfunction

	function automatic int unsigned cell_lo(input int unsigned i, input int unsigned cl,
			input int unsigned ex);
		return i * (cl + grid_border) + ((i < ex) ? i : ex);
	endfunction

	function automatic int unsigned cell_len(input int unsigned i, input int unsigned cl,
			input int unsigned ex);
		return cl + ((i < ex) ? 1 : 0);
	endfunction

	// Rectangle the block owes for one query under the current layout.
	// Arithmetic is 32-bit unsigned and only the final fields are cut to
	// coordinate width, so empty cells and zero borders wrap their end.
	function automatic result_t rect_of(input query_t q);
		int unsigned cl_x, ex_x, cl_y, ex_y;
		int unsigned sx, sy, w, h, r, c;
		status_t st;
		result_t res;
		res = '0;
		sx = 0;
		sy = 0;
		w = 0;
		h = 0;
		r = q.row_index;
		c = q.column_index;
		st = ST_SUCCESS;
		if (!axis_fits(grid_w, grid_cols) || !axis_fits(grid_h, grid_rows)) begin
			st = ST_INVALID_LAYOUT;
		end else begin
			axis_split(grid_w, grid_cols, cl_x, ex_x);
			axis_split(grid_h, grid_rows, cl_y, ex_y);
			case (q.kind)
				KIND_CELL: begin
					if (r >= grid_rows || c >= grid_cols) begin
						st = ST_INVALID_INDEX;
					end else begin
						sx = cell_lo(c, cl_x, ex_x);
						sy = cell_lo(r, cl_y, ex_y);
						w = cell_len(c, cl_x, ex_x);
						h = cell_len(r, cl_y, ex_y);
					end
				end
				KIND_VBORDER: begin
					// border k starts right after the last pixel of column k
					if (c + 1 >= grid_cols) begin
						st = ST_INVALID_INDEX;
					end else begin
						sx = cell_lo(c, cl_x, ex_x) + cell_len(c, cl_x, ex_x);
						w = grid_border;
						h = grid_h;
					end
				end
				KIND_HBORDER: begin
					if (r + 1 >= grid_rows) begin
						st = ST_INVALID_INDEX;
					end else begin
						sy = cell_lo(r, cl_y, ex_y) + cell_len(r, cl_y, ex_y);
						w = grid_w;
						h = grid_border;
					end
				end
				default: st = ST_INVALID_INDEX;
			endcase
		end
		res.status = st;
		if (st == ST_SUCCESS) begin
			res.start_x = coord_t'(sx);
			res.start_y = coord_t'(sy);
			res.end_x = coord_t'(sx + w - 1);
			res.end_y = coord_t'(sy + h - 1);
			res.box_width = coord_t'(w);
			res.box_height = coord_t'(h);
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Driver: takes queries from queries_todo, bursts with random gaps.
	// The prediction is made at the transfer edge, from the payload that
	// was actually accepted.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_valid <= 1'b0;
		end else begin
			if (query_valid && query_ready)
				rects_due.insert(rects_due.size(), rect_of(query));
			// free to present a new query only when nothing is pending
			if (!query_valid || query_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					query_valid <= 1'b0;
				end else if (queries_todo.size() > 0 &&
						!(queries_todo[0].drain && rects_due.size() > 0)) begin
					job = queries_todo.pop_front();
					query <= job.q;
					query_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						// a third of the bursts run straight into the next one
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					query_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transfer and paces result_ready.
	// ------------------------------------------------------------------
	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (rects_due.size() == 0) begin
					errors++;
					$display("%0t: result transfer with nothing expected, got %h",
						$time, result);
				end else begin
					check_field("status", rects_due[0].status, result.status);
					check_field("start_x", rects_due[0].start_x, result.start_x);
					check_field("start_y", rects_due[0].start_y, result.start_y);
					check_field("end_x", rects_due[0].end_x, result.end_x);
					check_field("end_y", rects_due[0].end_y, result.end_y);
					check_field("box_width", rects_due[0].box_width, result.box_width);
					check_field("box_height", rects_due[0].box_height, result.box_height);
					void'(rects_due.pop_front());
				end
				results_seen++;
				// long back-pressure so the pipeline fills and query_ready drops
				if (results_seen == 400 || results_seen == 900 || results_seen == 1500)
					hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				if (pace_left <= 0) begin
					rx_pace = rx_pace_t'($urandom_range(0, 2));
					pace_left = $urandom_range(10, 120);
				end else begin
					pace_left--;
				end
				case (rx_pace)
					RX_OPEN:   result_ready <= 1'b1;
					RX_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
					default:   result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any cycle with a transfer on either side counts as progress.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (query_valid && query_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic add_query(input logic [1:0] kind, input int unsigned row,
			input int unsigned col, input bit drain);
		query_job_t j;
		j.q.kind = kind;
		j.q.row_index = row[INDEX_BITS-1:0];
		j.q.column_index = col[INDEX_BITS-1:0];
		j.drain = drain;
		queries_todo.insert(queries_todo.size(), j);
	endtask

	// Idle means no query waiting or on the wire and every result back.
	// Sampled on the falling edge, where all clocked updates have settled.
	task automatic wait_idle();
		while (queries_todo.size() > 0 || query_valid || rects_due.size() > 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// One register write, mirrored in the bench copy with the register's width.
	// The block recomputes its cell lengths afterward; wait that out.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AREA_WIDTH:   grid_w = val[LEN_BITS-1:0];
			REG_AREA_HEIGHT:  grid_h = val[LEN_BITS-1:0];
			REG_ROW_COUNT:    grid_rows = val[COUNT_BITS-1:0];
			REG_COLUMN_COUNT: grid_cols = val[COUNT_BITS-1:0];
			default:          grid_border = val[BORDER_BITS-1:0];
		endcase
		@(posedge clk);
		while (!query_ready)
			@(posedge clk);
	endtask

	// Rewrite the whole layout; bits above a register's width carry noise.
	task automatic apply_layout(input int unsigned w, input int unsigned h,
			input int unsigned rows, input int unsigned cols, input int unsigned border);
		logic [CFG_DATA_BITS-1:0] d;
		wait_idle();
		write_reg(REG_AREA_WIDTH, w[CFG_DATA_BITS-1:0]);
		write_reg(REG_AREA_HEIGHT, h[CFG_DATA_BITS-1:0]);
		d = $urandom();
		d[COUNT_BITS-1:0] = rows[COUNT_BITS-1:0];
		write_reg(REG_ROW_COUNT, d);
		d = $urandom();
		d[COUNT_BITS-1:0] = cols[COUNT_BITS-1:0];
		write_reg(REG_COLUMN_COUNT, d);
		d = $urandom();
		d[BORDER_BITS-1:0] = border[BORDER_BITS-1:0];
		write_reg(REG_BORDER_WIDTH, d);
	endtask

	// Random axis, mostly usable; sometimes a bad count or borders that
	// overrun the length by one pixel. Small counts dominate.
	task automatic pick_axis(input int unsigned bw, output int unsigned len,
			output int unsigned n);
		int unsigned sel, need;
		sel = $urandom_range(0, 19);
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
		if (sel == 0) begin
			n = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(MAX_CELLS + 1, 127);
			len = $urandom_range(0, 4095);
		end else if (sel == 1) begin
			need = bw * (n - 1);
			len = (need >= 1 && need <= 4096) ? need - 1 : $urandom_range(0, 4095);
		end else begin
			while (bw * (n - 1) > 4095)
				n--;
			need = bw * (n - 1);
			// tight lengths give empty cells and a small remainder
			if (sel < 8)
				len = need + $urandom_range(0, 2 * n);
			else
				len = $urandom_range(need, 4095);
			if (len > 4095)
				len = 4095;
		end
	endtask

	initial begin
		int unsigned bw, w, h, rows, cols, sel, rmax, cmax, row, col;
		logic [1:0] kind;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset layout is 100x100, 3x3, border 10
		add_query(KIND_CELL, 0, 0, 0);
		add_query(KIND_CELL, 0, 2, 0);
		add_query(KIND_CELL, 2, 0, 0);
		add_query(KIND_CELL, 2, 2, 0);
		add_query(KIND_CELL, 1, 1, 0);
		add_query(KIND_CELL, 3, 0, 0);
		add_query(KIND_CELL, 0, 3, 0);
		add_query(KIND_CELL, 63, 63, 0);
		add_query(KIND_VBORDER, 0, 0, 0);
		add_query(KIND_VBORDER, 63, 1, 0);
		add_query(KIND_VBORDER, 0, 2, 0);
		add_query(KIND_VBORDER, 0, 63, 0);
		add_query(KIND_HBORDER, 0, 63, 0);
		add_query(KIND_HBORDER, 1, 0, 0);
		add_query(KIND_HBORDER, 2, 0, 0);
		add_query(KIND_UNUSED, 0, 0, 0);
		add_query(KIND_UNUSED, 63, 63, 0);

		// Full-size grid where the borders eat all but 63 pixels: every
		// cell is one pixel wide except the last, which is empty and wraps
		apply_layout(4095, 4095, 64, 64, 64);
		add_query(KIND_CELL, 0, 0, 0);
		add_query(KIND_CELL, 63, 63, 0);
		add_query(KIND_VBORDER, 0, 62, 0);
		add_query(KIND_HBORDER, 62, 0, 0);
		add_query(KIND_VBORDER, 0, 63, 0);

		// Zero columns: layout error wins over an unused kind
		apply_layout(100, 100, 3, 0, 10);
		add_query(KIND_CELL, 0, 0, 0);
		add_query(KIND_UNUSED, 0, 0, 0);

		// Random phases, a few of them pinned to extreme layouts
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				3:  apply_layout(4095, 4095, 64, 64, 65);	// borders fill exactly
				7:  apply_layout(1, 4095, 64, 1, 0);		// zero border, one column
				11: apply_layout(0, 0, 1, 1, 255);		// empty area
				15: apply_layout(4095, 1, 1, 64, 255);	// borders overrun
				default: begin
					sel = $urandom_range(0, 9);
					if (sel == 0)
						bw = 0;
					else if (sel < 4)
						bw = $urandom_range(0, 255);
					else
						bw = $urandom_range(0, 12);
					pick_axis(bw, w, cols);
					pick_axis(bw, h, rows);
					apply_layout(w, h, rows, cols, bw);
				end
			endcase

			for (int j = 0; j < PHASE_QUERIES; j++) begin
				sel = $urandom_range(0, 99);
				if (sel < 3)
					kind = KIND_UNUSED;
				else if (sel < 55)
					kind = KIND_CELL;
				else if (sel < 78)
					kind = KIND_VBORDER;
				else
					kind = KIND_HBORDER;
				// highest index that is still in range for this kind
				rmax = (kind == KIND_HBORDER) ? grid_rows - 2 : grid_rows - 1;
				cmax = (kind == KIND_VBORDER) ? grid_cols - 2 : grid_cols - 1;
				if (int'(rmax) >= 0 && rmax < 64 && $urandom_range(0, 9) != 0)
					row = $urandom_range(0, rmax);
				else
					row = $urandom_range(0, 63);
				if (int'(cmax) >= 0 && cmax < 64 && $urandom_range(0, 9) != 0)
					col = $urandom_range(0, cmax);
				else
					col = $urandom_range(0, 63);
				// now and then the sender stops until the pipeline is empty
				add_query(kind, row, col,
					(p == 5 && j == 45) || $urandom_range(0, 199) == 0);
			end
		end

		wait_idle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
